// ===== design/bos_pkg.sv =====
// Package: shared types and constants for the bounded ordered integer set.
`timescale 1ns / 1ps
`default_nettype none
package bos_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int LIMIT_W = 8;
	localparam int COUNT_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_GET    = 2'd3
	} mode_t;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic cap;     // capture hit flag for a new transaction
		logic is_get;  // hit compares position instead of value
		logic add_go;  // append at the cell whose index equals count
		logic del_go;  // shift down at and above the matching cell
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/bos_req_if.sv =====
// Interface: request channel (valid/ready with request payload).
`timescale 1ns / 1ps
`default_nettype none
interface bos_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic signed [31:0]       item_value;
	logic [7:0]               position;

	modport source(output valid, mode, item_value, position, input ready);
	modport sink(input valid, mode, item_value, position, output ready);
endinterface
`default_nettype wire

// ===== design/bos_rsp_if.sv =====
// Interface: response channel (valid/ready with result payload).
`timescale 1ns / 1ps
`default_nettype none
interface bos_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [31:0]       read_value;
	logic                     out_of_range;
	logic [7:0]               entry_count;

	modport source(output valid, found, read_value, out_of_range, entry_count, input ready);
	modport sink(input valid, found, read_value, out_of_range, entry_count, output ready);
endinterface
`default_nettype wire

// ===== design/bos_cell.sv =====
// Module: one storage cell of the set chain (entry, compare, shift).
`timescale 1ns / 1ps
`default_nettype none
module bos_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bos_pkg::cell_ctrl_t          ctrl,
	input  wire logic [CNT_W-1:0]             count,
	input  wire logic [bos_pkg::DATA_W-1:0]   cmp_value,
	input  wire logic [bos_pkg::POS_W-1:0]    position,
	input  wire logic [bos_pkg::DATA_W-1:0]   wr_value,
	input  wire logic                         shift_en,
	input  wire logic [bos_pkg::DATA_W-1:0]   next_value,
	output logic [bos_pkg::DATA_W-1:0]        value,
	output logic                              hit
);
	import bos_pkg::*;

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
	localparam logic [CMP_W-1:0] MY_POS = CMP_W'(IDX);

	logic [DATA_W-1:0] value_q;
	logic              hit_q;
	logic              valid;
	logic              match;

	assign valid = MY_IDX < count;
	assign match = ctrl.is_get ? (MY_POS == CMP_W'(position)) : (value_q == cmp_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.cap) begin
			hit_q <= valid & match;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add_go && (MY_IDX == count)) begin
			value_q <= wr_value;
		end else if (ctrl.del_go && shift_en) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;
	assign hit   = hit_q;

endmodule
`default_nettype wire

// ===== design/bounded_ordered_integer_set_core.sv =====
// Top level: bounded ordered integer set built from a chain of entry cells.
//
//  channel   dir   handshake         payload
//  req       in    valid / ready     mode, item_value, position
//  rsp       out   valid / ready     found, read_value, out_of_range, entry_count
//  cfg       in    cfg_we            cfg_wdata (set limit)
//
// In each transaction all cells compare in parallel at accept, then hits are
// reduced and the chain appends, shifts or is read.
// req.ready is high in the idle state, also while a result waits in rsp.
// A stalled rsp holds the block in its evaluate state; nothing is lost.
// Reset clears the count and restores the limit to 100; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_ordered_integer_set_core #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bos_pkg::LIMIT_W-1:0]   cfg_wdata,
	bos_req_if.sink                            req,
	bos_rsp_if.source                          rsp
);
	import bos_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t               state_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [CNT_W-1:0]     count_q;
	mode_t                mode_q;
	logic [DATA_W-1:0]    item_q;

	logic                 rsp_valid_q;
	logic                 found_q;
	logic [DATA_W-1:0]    read_value_q;
	logic                 oor_q;
	logic [COUNT_W-1:0]   count_out_q;

	logic                 in_fire;
	logic                 go;
	cell_ctrl_t           ctrl;
	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] pre_vec;
	logic [DATA_W-1:0]    cell_val [MAX_ENTRIES];
	logic                 any_hit;
	logic [DATA_W-1:0]    sel_val;
	logic [LW-1:0]        eff_limit;
	logic                 room;
	logic [CNT_W-1:0]     count_nxt;
	logic                 is_get;

	assign in_fire   = req.valid & req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign go        = (state_q == ST_EVAL) & (~rsp_valid_q | rsp.ready);
	assign is_get    = (mode_q == MODE_GET);

	assign eff_limit = (LW'(limit_q) < LW'(MAX_ENTRIES)) ? LW'(limit_q) : LW'(MAX_ENTRIES);
	assign room      = LW'(count_q) < eff_limit;

	always_comb begin
		any_hit = 1'b0;
		sel_val = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			any_hit = any_hit | hit_vec[i];
			if (hit_vec[i]) begin
				sel_val = sel_val | cell_val[i];
			end
		end
	end

	// Prefix OR: a cell shifts when the match sits at or below its index.
	always_comb begin
		pre_vec = hit_vec;
		for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
			pre_vec = pre_vec | (pre_vec << s);
		end
	end

	always_comb begin
		ctrl.cap    = in_fire;
		ctrl.is_get = (mode_t'(req.mode) == MODE_GET);
		ctrl.add_go = go & (mode_q == MODE_ADD) & ~any_hit & room;
		ctrl.del_go = go & (mode_q == MODE_REMOVE) & any_hit;
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.add_go) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.del_go) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [DATA_W-1:0] nxt;
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign nxt = cell_val[g];
		end else begin : g_mid
			assign nxt = cell_val[g+1];
		end
		bos_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (count_q),
			.cmp_value  (req.item_value),
			.position   (req.position),
			.wr_value   (item_q),
			.shift_en   (pre_vec[g]),
			.next_value (nxt),
			.value      (cell_val[g]),
			.hit        (hit_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (go) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode_t'(req.mode);
			item_q <= req.item_value;
		end
		if (go) begin
			found_q      <= ~is_get & any_hit;
			read_value_q <= is_get ? (any_hit ? sel_val : '1) : '0;
			oor_q        <= is_get & ~any_hit;
			count_out_q  <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = found_q;
	assign rsp.read_value   = read_value_q;
	assign rsp.out_of_range = oor_q;
	assign rsp.entry_count  = count_out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell hit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> count_q == $past(count_q))
		else $error("count changed outside evaluate");

	a_oor_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_of_range |-> rsp.read_value == '1)
		else $error("out of range result without all-ones value");
`endif

endmodule
`default_nettype wire

// ===== test/bounded_ordered_integer_set_core_tb.sv =====
// Testbench for the bounded ordered integer set: directed and randomized requests checked against a set model.
`timescale 1ns / 1ps

module bounded_ordered_integer_set_core_tb;
	import bos_pkg::*;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] item_value;
		logic [7:0]         position;
	} set_req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] read_value;
		logic               out_of_range;
		logic [7:0]         entry_count;
	} set_rsp_t;

	class set_tracker #(int DEPTH = 128);
		logic signed [31:0] members[DEPTH];
		int unsigned        count;
		int unsigned        limit;
		set_rsp_t           pending[$];
		int                 mismatches;
		int                 requests;
		int                 hits;
		int                 ignored_adds;
		int                 oor_gets;
		int unsigned        peak_count;

		function new();
			foreach (members[i]) members[i] = '0;
			count = 0;
			limit = 32'(LIMIT_RESET);
			mismatches = 0;
			requests = 0;
			hits = 0;
			ignored_adds = 0;
			oor_gets = 0;
			peak_count = 0;
		endfunction

		function void set_limit(logic [7:0] v);
			limit = 32'(v);
		endfunction

		function int pending_count();
			return pending.size();
		endfunction

		function logic signed [31:0] member_at(int unsigned idx);
			return members[idx];
		endfunction

		// Applies one request to the modeled set and returns the response it should produce.
		function set_rsp_t apply_request(set_req_t r);
			set_rsp_t    rsp;
			int unsigned idx;
			int unsigned lim;
			rsp = '0;
			lim = (limit < DEPTH) ? limit : DEPTH;
			if (r.mode == MODE_GET) begin
				if (r.position < count) begin
					rsp.read_value = members[r.position];
				end else begin
					rsp.read_value = -1;
					rsp.out_of_range = 1'b1;
					oor_gets++;
				end
			end else begin
				idx = count;
				for (int unsigned i = 0; i < count; i++)
					if (idx == count && members[i] == r.item_value) idx = i;
				rsp.found = (idx < count);
				if (rsp.found) hits++;
				if (r.mode == MODE_ADD) begin
					if (!rsp.found && count < lim) begin
						members[count] = r.item_value;
						count++;
					end else if (!rsp.found) begin
						ignored_adds++;
					end
				end else if (r.mode == MODE_REMOVE && rsp.found) begin
					for (int unsigned i = idx; i + 1 < count; i++)
						members[i] = members[i + 1];
					count--;
				end
			end
			if (count > peak_count) peak_count = count;
			rsp.entry_count = count[7:0];
			return rsp;
		endfunction

		function void note_request(set_req_t r);
			requests++;
			pending.push_back(apply_request(r));
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) $display("MISMATCH: %s", msg);
		endfunction

		function void check_response(set_rsp_t got);
			set_rsp_t want;
			if (pending.size() == 0) begin
				note_mismatch($sformatf("response with none pending: found=%0b read_value=%0d oor=%0b count=%0d",
					got.found, got.read_value, got.out_of_range, got.entry_count));
				return;
			end
			want = pending.pop_front();
			if (got.found !== want.found)
				note_mismatch($sformatf("found: expected %0b, got %0b", want.found, got.found));
			if (got.read_value !== want.read_value)
				note_mismatch($sformatf("read_value: expected %0d, got %0d",
					want.read_value, got.read_value));
			if (got.out_of_range !== want.out_of_range)
				note_mismatch($sformatf("out_of_range: expected %0b, got %0b",
					want.out_of_range, got.out_of_range));
			if (got.entry_count !== want.entry_count)
				note_mismatch($sformatf("entry_count: expected %0d, got %0d",
					want.entry_count, got.entry_count));
		endfunction
	endclass

	localparam int SET_DEPTH   = 128;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       start_hold;
	logic       rx_hold;
	int         cycle_count = 0;
	int         limits_used = 0;

	logic signed [31:0] value_pool[256];
	set_tracker #(SET_DEPTH) tracker;

	bos_req_if req_ch();
	bos_rsp_if rsp_ch();

	bounded_ordered_integer_set_core #(
		.MAX_ENTRIES(SET_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding",
				cycle_count, tracker.pending_count());
			$display("Verification failed");
			$finish;
		end
	end

	// One long receiver stall, started once by the stimulus.
	initial begin : receiver_hold
		rx_hold = 1'b0;
		@(posedge start_hold);
		rx_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : response_sink
		logic [15:0] ready_pattern;
		int          pattern_age;
		set_rsp_t    got;
		rsp_ch.ready = 1'b0;
		ready_pattern = 16'hFFFF;
		pattern_age = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.found = rsp_ch.found;
				got.read_value = rsp_ch.read_value;
				got.out_of_range = rsp_ch.out_of_range;
				got.entry_count = rsp_ch.entry_count;
				tracker.check_response(got);
			end
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(32, 96);
				case ($urandom_range(3))
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'($urandom);
					2: ready_pattern = 16'($urandom | $urandom);
					default: ready_pattern = 16'h8001;
				endcase
				if (ready_pattern == '0) ready_pattern = 16'h0001;
			end
			pattern_age--;
			rsp_ch.ready <= ~rx_hold & ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
	end

	// Offers one request and returns at the edge where it is accepted; valid stays high.
	task automatic issue(mode_t m, logic signed [31:0] v, logic [7:0] p);
		set_req_t r;
		r.mode = m;
		r.item_value = v;
		r.position = p;
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.item_value <= v;
		req_ch.position <= p;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_request(r);
	endtask

	// Limit writes only once every response is back.
	task automatic write_limit(logic [7:0] v);
		req_ch.valid <= 1'b0;
		while (tracker.pending_count() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_limit(v);
		limits_used++;
	endtask

	task automatic run_phase(logic [7:0] lim, int n, int pool_n, int add_pct, bit long_hold);
		int                 done;
		int                 burst;
		int                 gap;
		int                 r;
		int                 share;
		mode_t              m;
		logic signed [31:0] v;
		logic [7:0]         p;
		write_limit(lim);
		if (long_hold) start_hold <= 1'b1;
		share = (100 - add_pct) / 3;
		done = 0;
		while (done < n) begin
			burst = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			for (int k = 0; k < burst && done < n; k++) begin
				r = $urandom_range(99);
				if (r < add_pct) m = MODE_ADD;
				else if (r < add_pct + share) m = MODE_REMOVE;
				else if (r < add_pct + 2 * share) m = MODE_QUERY;
				else m = MODE_GET;
				r = $urandom_range(9);
				if (m != MODE_ADD && tracker.count > 0 && r < 4) begin
					v = tracker.member_at($urandom_range(tracker.count - 1));
				end else if (r == 9) begin
					v = $urandom;
				end else if (r == 8) begin
					case ($urandom_range(3))
						0: v = VAL_MIN;
						1: v = VAL_MAX;
						2: v = 0;
						default: v = -1;
					endcase
				end else begin
					v = value_pool[$urandom_range(pool_n - 1)];
				end
				if (m == MODE_GET && $urandom_range(5) != 0)
					p = 8'($urandom_range(tracker.count + 1));
				else
					p = 8'($urandom_range(255));
				issue(m, v, p);
				done++;
			end
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start_hold = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_ADD;
		req_ch.item_value = '0;
		req_ch.position = '0;
		foreach (value_pool[i]) value_pool[i] = $urandom;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 0;
		value_pool[3] = -1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty get, extremes, duplicate, first/middle/last removal, absent removal.
		issue(MODE_GET, 0, 8'd0);
		issue(MODE_ADD, VAL_MIN, 8'd0);
		issue(MODE_ADD, VAL_MAX, 8'd0);
		issue(MODE_ADD, 0, 8'd0);
		issue(MODE_ADD, -1, 8'd0);
		issue(MODE_ADD, VAL_MIN, 8'd0);
		issue(MODE_QUERY, VAL_MAX, 8'd0);
		issue(MODE_QUERY, 1, 8'd0);
		issue(MODE_GET, 0, 8'd0);
		issue(MODE_GET, 0, 8'd3);
		issue(MODE_GET, 0, 8'd4);
		issue(MODE_GET, -1, 8'd255);
		issue(MODE_REMOVE, VAL_MIN, 8'd0);
		issue(MODE_GET, 0, 8'd0);
		issue(MODE_REMOVE, 12345, 8'd0);
		issue(MODE_REMOVE, -1, 8'd0);
		issue(MODE_ADD, 32'h5555_5555, 8'd0);
		issue(MODE_ADD, 32'hAAAA_AAAA, 8'd0);
		issue(MODE_REMOVE, 0, 8'd0);
		issue(MODE_GET, 0, 8'd1);
		// Limit dropped below the count: held entries stay, adds ignored until room.
		write_limit(8'd2);
		issue(MODE_ADD, 7, 8'd0);
		issue(MODE_REMOVE, 32'h5555_5555, 8'd0);
		issue(MODE_ADD, 7, 8'd0);
		issue(MODE_REMOVE, VAL_MAX, 8'd0);
		issue(MODE_ADD, 7, 8'd0);
		write_limit(8'd0);
		issue(MODE_ADD, 9, 8'd0);
		issue(MODE_QUERY, 7, 8'd0);

		// Random: limit above depth with fill to full, then churn across limits.
		run_phase(8'd255, 220, 256, 90, 1'b1);
		run_phase(8'd128, 60, 256, 40, 1'b0);
		run_phase(8'd5, 80, 200, 20, 1'b0);
		run_phase(8'd0, 30, 16, 50, 1'b0);
		run_phase(8'd16, 100, 24, 45, 1'b0);
		run_phase(8'd100, 80, 150, 60, 1'b0);
		run_phase(8'd1, 40, 4, 40, 1'b0);
		run_phase(8'd128, 40, 256, 70, 1'b0);

		req_ch.valid <= 1'b0;
		while (tracker.pending_count() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d requests under %0d limit settings; peak occupancy %0d of %0d.",
			tracker.requests, limits_used + 1, tracker.peak_count, SET_DEPTH);
		$display("Hits %0d, ignored adds %0d, out-of-range gets %0d, mismatches %0d.",
			tracker.hits, tracker.ignored_adds, tracker.oor_gets, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/bos_pkg.sv
design/bos_req_if.sv
design/bos_rsp_if.sv
design/bos_cell.sv
design/bounded_ordered_integer_set_core.sv
test/bounded_ordered_integer_set_core_tb.sv
